>>> hw/rtl/rcsd_pkg.sv
// ---------------------------------------------------------------------------
// rcsd_pkg: shared types and constants
// phase codes, per-stream context word, result word and header lengths
// ---------------------------------------------------------------------------
package rcsd_pkg;

  localparam int STREAM_SLOTS = 64;
  localparam int SLOT_W       = $clog2(STREAM_SLOTS);
  localparam int CID_W        = 17;
  localparam int CSIZE_W      = 17;
  localparam logic [CSIZE_W-1:0] CHUNK_SIZE_RESET = 17'd128;
  localparam logic [23:0] DELTA_EXT = 24'hffffff;
  localparam logic [31:0] BASIC_EXT_BASE = 32'd64;

  typedef enum logic [4:0] {
    PH_BASIC     = 5'b00001,
    PH_BASIC_EXT = 5'b00010,
    PH_MSG       = 5'b00100,
    PH_EXT_TS    = 5'b01000,
    PH_PAYLOAD   = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NOT_FMT0   = 2'd0;
  localparam logic [1:0] ERR_FMT0_OPEN  = 2'd1;
  localparam logic [1:0] ERR_LEN_CHANGE = 2'd2;
  localparam logic [1:0] ERR_CID_RANGE  = 2'd3;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [30:0] ts;
    logic [23:0] delta;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] msg_id;
    logic [23:0] recv;
    logic        ext;
    logic        open;
    logic        started;
  } ctx_t;

  typedef struct packed {
    phase_t             phase;
    logic [3:0]         hbc;
    logic [CID_W-1:0]   stream;
    logic [31:0]        asm_word;
    logic [CSIZE_W-1:0] cbl;
    logic               halted;
  } ctl_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CID_W-1:0] cid;
    logic [7:0]       mtype;
    logic [23:0]      len;
    logic [30:0]      ts;
    logic [31:0]      msg_id;
    logic [7:0]       pbyte;
    logic             last;
    logic [1:0]       ecode;
  } res_t;

  function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
    logic [3:0] r;
    unique case (fmt)
      2'd0:    r = 4'd11;
      2'd1:    r = 4'd7;
      2'd2:    r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/rcsd_if.sv
// ---------------------------------------------------------------------------
// rcsd channel interfaces
// byte input, result output and chunk size write channels
// ---------------------------------------------------------------------------
interface rcsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rcsd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [16:0] chunk_stream_id;
  logic [7:0]  type_id;
  logic [23:0] msg_length;
  logic [30:0] timestamp;
  logic [31:0] message_stream_id;
  logic [7:0]  payload_byte;
  logic        last_in_message;
  logic [1:0]  error_code;
  modport source (output valid, output kind, output chunk_stream_id, output type_id,
                  output msg_length, output timestamp, output message_stream_id,
                  output payload_byte, output last_in_message, output error_code,
                  input ready);
  modport sink (input valid, input kind, input chunk_stream_id, input type_id,
                input msg_length, input timestamp, input message_stream_id,
                input payload_byte, input last_in_message, input error_code,
                output ready);
endinterface

interface rcsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] chunk_size;
  modport source (output valid, output chunk_size, input ready);
  modport sink (input valid, input chunk_size, output ready);
endinterface

>>> hw/rtl/rcsd_ctx_store.sv
// ---------------------------------------------------------------------------
// rcsd_ctx_store: per-stream context memory
// one write and one registered read port, valid bits make unwritten slots zero
// ---------------------------------------------------------------------------
module rcsd_ctx_store (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [rcsd_pkg::SLOT_W-1:0] rd_addr,
  output rcsd_pkg::ctx_t       rd_data,
  input  logic                 wr_en,
  input  logic [rcsd_pkg::SLOT_W-1:0] wr_addr,
  input  rcsd_pkg::ctx_t       wr_data
);
  import rcsd_pkg::*;

  ctx_t                    mem [STREAM_SLOTS];
  logic [STREAM_SLOTS-1:0] slot_valid;
  ctx_t                    rd_q;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= slot_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;
endmodule

>>> hw/rtl/rcsd_step.sv
// ---------------------------------------------------------------------------
// rcsd_step: one byte of chunk parsing
// next parser state, updated stream context and optional result
// ---------------------------------------------------------------------------
module rcsd_step (
  input  rcsd_pkg::ctl_t  ctl,
  input  logic [16:0]     chunk_size,
  input  logic [7:0]      data_byte,
  input  rcsd_pkg::ctx_t  work,
  input  rcsd_pkg::ctx_t  fetched,
  output rcsd_pkg::ctl_t  ctl_next,
  output rcsd_pkg::ctx_t  ctx_next,
  output logic            wr_en,
  output logic            res_valid,
  output rcsd_pkg::res_t  res
);
  import rcsd_pkg::*;

  ctx_t        c;
  ctl_t        n;
  logic        do_start, do_end, do_finish, err, first;
  logic [1:0]  ecode, sfmt;
  logic [16:0] scid;
  logic [31:0] sum, a;
  logic [23:0] left24;
  logic [16:0] csz;
  logic [3:0]  i;
  logic [1:0]  rkind;
  logic        rlast;

  always_comb begin
    c = work;
    n = ctl;
    do_start = 1'b0;
    do_end = 1'b0;
    do_finish = 1'b0;
    err = 1'b0;
    ecode = ERR_NOT_FMT0;
    sfmt = data_byte[7:6];
    scid = {11'd0, data_byte[5:0]};
    sum = '0;
    a = '0;
    left24 = '0;
    csz = '0;
    first = 1'b0;
    i = ctl.hbc;
    res_valid = 1'b0;
    rkind = KIND_HEADER;
    rlast = 1'b0;

    unique case (ctl.phase)
      PH_BASIC: begin
        if (data_byte[5:0] >= 6'd2) begin
          do_start = 1'b1;
        end else begin
          n.asm_word = {6'd0, data_byte[7:6], 24'd0} | BASIC_EXT_BASE;
          n.hbc = (data_byte[5:0] == 6'd1) ? 4'd1 : 4'd2;
          n.phase = PH_BASIC_EXT;
        end
      end
      PH_BASIC_EXT: begin
        if (ctl.hbc == 4'd2) begin
          n.asm_word = (ctl.asm_word + {24'd0, data_byte}) | 32'h1000_0000;
          n.hbc = 4'd1;
        end else begin
          sum = ctl.asm_word[28] ? ctl.asm_word + {16'd0, data_byte, 8'd0}
                                 : ctl.asm_word + {24'd0, data_byte};
          n.asm_word = sum;
          scid = sum[16:0];
          sfmt = sum[25:24];
          do_start = 1'b1;
        end
      end
      PH_MSG: begin
        a = (i == 4'd0 || i == 4'd3 || i == 4'd7) ? 32'd0 : ctl.asm_word;
        if (i < 4'd7) begin
          a = {a[23:0], data_byte};
        end else begin
          a = {data_byte, a[31:8]};
        end
        n.asm_word = a;
        if (i == 4'd2) begin
          c.delta = a[23:0];
          if (a[23:0] == DELTA_EXT) begin
            c.ext = 1'b1;
          end else begin
            c.ext = 1'b0;
            c.ts = (c.fmt == 2'd0) ? {7'd0, a[23:0]} : c.ts + {7'd0, a[23:0]};
          end
        end else if (i == 4'd5) begin
          if (c.open && c.len != a[23:0]) begin
            err = 1'b1;
            ecode = ERR_LEN_CHANGE;
          end else begin
            c.len = a[23:0];
          end
        end else if (i == 4'd6) begin
          c.mtype = data_byte;
        end else if (i == 4'd10) begin
          c.msg_id = a;
        end
        if (!err) begin
          n.hbc = i + 4'd1;
          if (n.hbc >= hdr_len(c.fmt)) begin
            do_end = 1'b1;
          end
        end
      end
      PH_EXT_TS: begin
        a = {ctl.asm_word[23:0], data_byte};
        n.asm_word = a;
        n.hbc = ctl.hbc + 4'd1;
        if (n.hbc >= 4'd4) begin
          if (!(c.open && c.ts != 31'd0 && c.ts != a[30:0])) begin
            c.ts = a[30:0];
          end
          do_finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        c.recv = c.recv + 24'd1;
        n.cbl = (ctl.cbl != '0) ? ctl.cbl - 17'd1 : '0;
        if (c.recv >= c.len) begin
          rlast = 1'b1;
          c.open = 1'b0;
          n.phase = PH_BASIC;
        end else if (n.cbl == '0) begin
          n.phase = PH_BASIC;
        end
        res_valid = 1'b1;
        rkind = KIND_PAYLOAD;
      end
      default: begin
        n.phase = PH_BASIC;
      end
    endcase

    // start of a chunk: switch to the stream's context and vet the fmt
    if (do_start) begin
      n.stream = scid;
      if (scid >= 17'(STREAM_SLOTS)) begin
        err = 1'b1;
        ecode = ERR_CID_RANGE;
      end else begin
        c = (scid == ctl.stream) ? work : fetched;
        c.fmt = sfmt;
        if (!c.started && sfmt != 2'd0 && !(scid == 17'd2 && sfmt == 2'd1)) begin
          err = 1'b1;
          ecode = ERR_NOT_FMT0;
        end else if (c.open && sfmt == 2'd0) begin
          err = 1'b1;
          ecode = ERR_FMT0_OPEN;
        end else begin
          n.hbc = 4'd0;
          n.asm_word = '0;
          if (sfmt == 2'd3) begin
            if (!c.open && !c.ext) begin
              c.ts = c.ts + {7'd0, c.delta};
            end
            do_end = 1'b1;
          end else begin
            n.phase = PH_MSG;
          end
        end
      end
    end

    if (do_end) begin
      if (c.ext) begin
        n.phase = PH_EXT_TS;
        n.hbc = 4'd0;
        n.asm_word = '0;
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      first = !c.open;
      c.started = 1'b1;
      if (c.len == 24'd0) begin
        c.open = 1'b0;
        n.phase = PH_BASIC;
      end else begin
        if (first) begin
          c.open = 1'b1;
          c.recv = 24'd0;
        end
        left24 = c.len - c.recv;
        csz = (chunk_size == '0) ? 17'd1 : chunk_size;
        n.cbl = (left24 > {7'd0, csz}) ? csz : left24[16:0];
        n.phase = (left24 != 24'd0) ? PH_PAYLOAD : PH_BASIC;
        if (first) begin
          res_valid = 1'b1;
          rkind = KIND_HEADER;
        end
      end
    end

    res.kind   = rkind;
    res.cid    = n.stream;
    res.mtype  = c.mtype;
    res.len    = c.len;
    res.ts     = c.ts;
    res.msg_id = c.msg_id;
    res.pbyte  = (rkind == KIND_PAYLOAD) ? data_byte : 8'd0;
    res.last   = rlast;
    res.ecode  = 2'd0;

    if (err) begin
      res_valid = 1'b1;
      res = '0;
      res.kind = KIND_ERROR;
      res.cid = n.stream;
      res.ecode = ecode;
      n.halted = 1'b1;
      n.phase = PH_BASIC;
    end

    wr_en = !err && (n.stream < 17'(STREAM_SLOTS));

    if (ctl.halted) begin
      n = ctl;
      c = work;
      res_valid = 1'b0;
      wr_en = 1'b0;
    end

    ctl_next = n;
    ctx_next = c;
  end
endmodule

>>> hw/rtl/rtmp_chunk_stream_decoder.sv
// ---------------------------------------------------------------------------
// rtmp_chunk_stream_decoder: chunk stream demultiplexer
// parses basic and message headers byte by byte, tracks per-stream context
// and emits header, payload and error results
// ---------------------------------------------------------------------------
//  channel  dir  beat carries
//  in_ch    in   data_byte, one chunk stream byte
//  out_ch   out  kind, stream id, header fields, payload byte, last, error code
//  cfg      in   chunk_size, max payload bytes per incoming chunk
//
//  one byte per cycle sustained while out_ch is not stalled; the context memory
//  read happens at the edge that accepts a byte into the stage register, and
//  parsing writes the byte's result into the result register as the stage advances
//  rst clears the parser and all stream slot valid bits at once, no sweep
//  a stalled out_ch holds the result and the stage register, input stalls
//  behind them; cfg is always ready
// ---------------------------------------------------------------------------
module rtmp_chunk_stream_decoder (
  input  logic               clk,
  input  logic               rst,
  rcsd_byte_if.sink          in_ch,
  rcsd_result_if.source      out_ch,
  rcsd_cfg_if.sink           cfg
);
  import rcsd_pkg::*;

  // parser control and working copy of the current stream's context
  ctl_t        ctl, ctl_next, ctl_eff;
  ctx_t        work, ctx_next, fetched;
  logic [16:0] chunk_size;

  // stage register: byte whose context read is done, waiting to be parsed
  logic        s1_valid;
  logic [7:0]  s1_byte;

  // result register
  logic        o_valid;
  res_t        o_res;

  logic        adv, in_fire, wr_en, res_valid;
  res_t        res;
  logic [31:0] ext_sum;
  logic [SLOT_W-1:0] rd_addr;

  assign adv       = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || adv;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg.ready = 1'b1;

  rcsd_step u_step (
    .ctl        (ctl),
    .chunk_size (chunk_size),
    .data_byte  (s1_byte),
    .work       (work),
    .fetched    (fetched),
    .ctl_next   (ctl_next),
    .ctx_next   (ctx_next),
    .wr_en      (wr_en),
    .res_valid  (res_valid),
    .res        (res)
  );

  // parser state as seen by the byte entering now
  assign ctl_eff = adv ? ctl_next : ctl;
  assign ext_sum = ctl_eff.asm_word[28]
                 ? ctl_eff.asm_word + {16'd0, in_ch.data_byte, 8'd0}
                 : ctl_eff.asm_word + {24'd0, in_ch.data_byte};

  // slot to read for the entering byte: the stream it may open, else the current one
  always_comb begin
    priority if (ctl_eff.phase == PH_BASIC) begin
      rd_addr = in_ch.data_byte[SLOT_W-1:0];
    end else if (ctl_eff.phase == PH_BASIC_EXT && ctl_eff.hbc == 4'd1) begin
      rd_addr = ext_sum[SLOT_W-1:0];
    end else begin
      rd_addr = ctl_eff.stream[SLOT_W-1:0];
    end
  end

  rcsd_ctx_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (fetched),
    .wr_en   (adv && wr_en),
    .wr_addr (ctl_next.stream[SLOT_W-1:0]),
    .wr_data (ctx_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= '{phase: PH_BASIC, hbc: '0, stream: '0, asm_word: '0, cbl: '0,
                      halted: 1'b0};
      work       <= '0;
      chunk_size <= CHUNK_SIZE_RESET;
      s1_valid   <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        chunk_size <= cfg.chunk_size;
      end
      if (adv) begin
        ctl  <= ctl_next;
        work <= ctx_next;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        o_valid <= res_valid;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= in_ch.data_byte;
    end
    if (adv && res_valid) begin
      o_res <= res;
    end
  end

  assign out_ch.valid             = o_valid;
  assign out_ch.kind              = o_res.kind;
  assign out_ch.chunk_stream_id   = o_res.cid;
  assign out_ch.type_id           = o_res.mtype;
  assign out_ch.msg_length        = o_res.len;
  assign out_ch.timestamp         = o_res.ts;
  assign out_ch.message_stream_id = o_res.msg_id;
  assign out_ch.payload_byte      = o_res.pbyte;
  assign out_ch.last_in_message   = o_res.last;
  assign out_ch.error_code        = o_res.ecode;
endmodule

>>> hw/rtl/rcsd_checker.sv
// ---------------------------------------------------------------------------
// rcsd_checker: port level checks
// result field consistency and halt after an error beat
// ---------------------------------------------------------------------------
module rcsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] payload_byte,
  input logic       last_in_message,
  input logic [1:0] error_code
);
  import rcsd_pkg::*;

  // nothing follows a delivered error
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == KIND_ERROR |=> !out_valid)
    else $error("result after error beat");

  a_ecode: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERROR |-> error_code == 2'd0)
    else $error("error code on non-error beat");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> !last_in_message && payload_byte == 8'd0)
    else $error("payload fields on non-payload beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte))
    else $error("stalled beat changed");
endmodule

bind rtmp_chunk_stream_decoder rcsd_checker u_rcsd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .kind            (out_ch.kind),
  .payload_byte    (out_ch.payload_byte),
  .last_in_message (out_ch.last_in_message),
  .error_code      (out_ch.error_code)
);
